FILE: rtl/key_chatter_filter_core_assert.svh
// Assertion macros for the key chatter filter core.
`ifndef KEY_CHATTER_FILTER_CORE_ASSERT_SVH
`define KEY_CHATTER_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kcf_pkg.sv
// Shared types and constants for the key chatter filter.
package kcf_pkg;

    localparam int OP_W          = 2;
    localparam int KEY_CODE_W    = 7;
    localparam int KEY_SPAN      = 1 << KEY_CODE_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;
    localparam int OUT_ELAPSED_W = 32;

    localparam logic [OP_W-1:0] OP_PRESS    = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_HOLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HOLD = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DEFAULT_HOLD_RESET = CFG_DATA_W'(40 * 1000);

    typedef struct packed {
        logic forward;
        logic rel_write;
        logic hold_write;
    } t_ctl;

endpackage

FILE: rtl/kcf_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module kcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kcf_check.sv
// Per-event decision: filter test, elapsed time, hold compare and write strobes.
module kcf_check #(
    parameter int TIME_BITS = 32,
    parameter int HOLD_BITS = 24
) (
    input  logic [kcf_pkg::OP_W-1:0]       i_op,
    input  logic                           i_filter_all,
    input  logic [kcf_pkg::CFG_DATA_W-1:0] i_default_hold,
    input  logic                           i_seen,
    input  logic                           i_present,
    input  logic [HOLD_BITS-1:0]           i_hold_val,
    input  logic [TIME_BITS-1:0]           i_now,
    input  logic [TIME_BITS-1:0]           i_last,
    output kcf_pkg::t_ctl                  o_ctl,
    output logic [TIME_BITS-1:0]           o_elapsed
);
    import kcf_pkg::*;

    localparam int TH_W  = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;
    localparam int CMP_W = (TH_W > CFG_DATA_W) ? TH_W : CFG_DATA_W;

    logic                 w_filtered;
    logic [TIME_BITS-1:0] w_gap;
    logic [CMP_W-1:0]     w_hold;

    assign w_filtered = i_filter_all | i_present;
    assign w_gap      = i_now - i_last;
    // a zero per-key entry falls back to the default register
    assign w_hold     = (i_present && (i_hold_val != '0)) ? CMP_W'(i_hold_val)
                                                          : CMP_W'(i_default_hold);

    always_comb begin
        o_ctl     = '{forward: 1'b1, rel_write: 1'b0, hold_write: 1'b0};
        o_elapsed = '0;
        case (i_op)
            OP_PRESS: begin
                if (w_filtered && i_seen) begin
                    o_elapsed     = w_gap;
                    o_ctl.forward = (CMP_W'(w_gap) >= w_hold);
                end
            end
            OP_RELEASE: begin
                o_ctl.rel_write = w_filtered;
            end
            OP_SET_HOLD: begin
                o_ctl.forward    = 1'b0;
                o_ctl.hold_write = 1'b1;
            end
            default: begin
                o_ctl.forward = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/key_chatter_filter_core.sv
// Top level of the key chatter filter: read stage, decision stage, output register.
//
//  channel | valid        | flow control | payload
//  --------+--------------+--------------+------------------------------------------
//  in      | i_in_valid   | o_in_stall   | i_opcode i_key_code i_time_us i_hold_us
//  out     | o_out_valid  | i_out_stall  | o_forward o_elapsed_us
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index i_cfg_data
//
// One request per cycle while the input is not stalled; an accepted request is registered into the
// read stage, and its decision is then registered in the output register, where it can be taken.
// The per-key RAM read is followed by one subtract and compare; a write-back to the key just
// read is forwarded into the next request.
// Reset clears the release-seen and hold-present bits at once; no clearing pass.
// A stall on the output holds the decision stage and, while that stage is full, stalls the input.
`include "key_chatter_filter_core_assert.svh"

module key_chatter_filter_core #(
    parameter int NUM_KEYS  = 128,
    parameter int TIME_BITS = 32,
    parameter int HOLD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [kcf_pkg::OP_W-1:0]          i_opcode,
    input  logic [kcf_pkg::KEY_CODE_W-1:0]    i_key_code,
    input  logic [TIME_BITS-1:0]              i_time_us,
    input  logic [HOLD_BITS-1:0]              i_hold_us,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_forward,
    output logic [kcf_pkg::OUT_ELAPSED_W-1:0] o_elapsed_us,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import kcf_pkg::*;

    localparam int KEY_W = $clog2(NUM_KEYS);

    // key code to table index, reduced modulo the table size
    logic [KEY_W-1:0] w_key_map [KEY_SPAN];
    for (genvar g = 0; g < KEY_SPAN; g++) begin : g_key_map
        assign w_key_map[g] = KEY_W'(g % NUM_KEYS);
    end

    logic                  r_filter_all;
    logic [CFG_DATA_W-1:0] r_default_hold;
    logic [NUM_KEYS-1:0]   r_release_seen;
    logic [NUM_KEYS-1:0]   r_hold_present;

    logic                  r_s1_valid;
    logic [OP_W-1:0]       r_s1_op;
    logic [KEY_W-1:0]      r_s1_key;
    logic [TIME_BITS-1:0]  r_s1_time;
    logic [HOLD_BITS-1:0]  r_s1_hold;

    logic                  r_fwd_rel_hit;
    logic [TIME_BITS-1:0]  r_fwd_rel_data;
    logic                  r_fwd_hold_hit;
    logic [HOLD_BITS-1:0]  r_fwd_hold_data;

    logic                  r_out_valid;
    logic                  r_out_forward;
    logic [TIME_BITS-1:0]  r_out_elapsed;

    logic                  w_accept;
    logic                  w_s1_adv;
    logic                  w_s1_fire;
    logic [KEY_W-1:0]      w_key;
    logic [TIME_BITS-1:0]  w_rel_rdata;
    logic [HOLD_BITS-1:0]  w_hold_rdata;
    logic [TIME_BITS-1:0]  w_last;
    logic [HOLD_BITS-1:0]  w_hold_val;
    t_ctl                  w_ctl;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic                  w_rel_we;
    logic                  w_hold_we;

    assign w_key      = w_key_map[i_key_code];
    assign w_s1_adv   = !r_out_valid || !i_out_stall;
    assign w_s1_fire  = r_s1_valid && w_s1_adv;
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rel_we   = w_s1_fire && w_ctl.rel_write;
    assign w_hold_we  = w_s1_fire && w_ctl.hold_write;
    assign o_cfg_ready = 1'b1;

    kcf_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_KEYS)
    ) u_rel_ram (
        .i_clk   (i_clk),
        .i_we    (w_rel_we),
        .i_waddr (r_s1_key),
        .i_wdata (r_s1_time),
        .i_re    (w_accept),
        .i_raddr (w_key),
        .o_rdata (w_rel_rdata)
    );

    kcf_ram #(
        .WIDTH (HOLD_BITS),
        .DEPTH (NUM_KEYS)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (w_hold_we),
        .i_waddr (r_s1_key),
        .i_wdata (r_s1_hold),
        .i_re    (w_accept),
        .i_raddr (w_key),
        .o_rdata (w_hold_rdata)
    );

    assign w_last     = r_fwd_rel_hit  ? r_fwd_rel_data  : w_rel_rdata;
    assign w_hold_val = r_fwd_hold_hit ? r_fwd_hold_data : w_hold_rdata;

    kcf_check #(
        .TIME_BITS (TIME_BITS),
        .HOLD_BITS (HOLD_BITS)
    ) u_check (
        .i_op           (r_s1_op),
        .i_filter_all   (r_filter_all),
        .i_default_hold (r_default_hold),
        .i_seen         (r_release_seen[r_s1_key]),
        .i_present      (r_hold_present[r_s1_key]),
        .i_hold_val     (w_hold_val),
        .i_now          (r_s1_time),
        .i_last         (w_last),
        .o_ctl          (w_ctl),
        .o_elapsed      (w_elapsed)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_all   <= 1'b0;
            r_default_hold <= DEFAULT_HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FILTER_ALL:   r_filter_all   <= i_cfg_data[0];
                CFG_DEFAULT_HOLD: r_default_hold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per-key flag bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_seen <= '0;
            r_hold_present <= '0;
        end else begin
            if (w_rel_we) begin
                r_release_seen[r_s1_key] <= 1'b1;
            end
            if (w_hold_we) begin
                r_hold_present[r_s1_key] <= 1'b1;
            end
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_fwd_rel_hit  <= 1'b0;
            r_fwd_hold_hit <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid     <= 1'b1;
                // the RAM returns old data when the request ahead writes the same key
                r_fwd_rel_hit  <= w_rel_we  && (r_s1_key == w_key);
                r_fwd_hold_hit <= w_hold_we && (r_s1_key == w_key);
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op         <= i_opcode;
            r_s1_key        <= w_key;
            r_s1_time       <= i_time_us;
            r_s1_hold       <= i_hold_us;
            r_fwd_rel_data  <= r_s1_time;
            r_fwd_hold_data <= r_s1_hold;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_forward <= w_ctl.forward;
            r_out_elapsed <= w_elapsed;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_forward    = r_out_forward;
    assign o_elapsed_us = OUT_ELAPSED_W'(64'(r_out_elapsed));

    `KCF_ASSERT_NOW(a_empty_stage_takes, i_clk, i_rst_n, !r_s1_valid, !o_in_stall,
        "input stalled with an empty decision stage")
    `KCF_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, w_s1_fire, o_out_valid,
        "decision left the stage but no result is shown")
    `KCF_ASSERT_NEXT(a_release_marks_seen, i_clk, i_rst_n, w_rel_we,
        r_release_seen[$past(r_s1_key)], "recorded release did not set its seen bit")
    `KCF_ASSERT_NEXT(a_setup_marks_present, i_clk, i_rst_n, w_hold_we,
        r_hold_present[$past(r_s1_key)], "hold set-up did not set its present bit")

endmodule
